/* rtl/core/ocs_pkg.sv */
// ----------------------------------------------------------------------------
// ocs_pkg
// Shared types and codes for the ordered coordinate set: transaction payloads,
// operation and status codes, and the control word of one storage cell.
// ----------------------------------------------------------------------------
package ocs_pkg;

  // Fixed field widths of the transaction payloads
  localparam int XY_W    = 8;
  localparam int POS_W   = 6;
  localparam int CNTO_W  = 7;
  localparam int RND_W   = 16;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_PICK   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_PRESENT  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [XY_W-1:0]  coord_x;
    logic [XY_W-1:0]  coord_y;
    logic [POS_W-1:0] entry_index;
    logic [RND_W-1:0] random_value;
  } ocs_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [POS_W-1:0]  position;
    logic [XY_W-1:0]   out_x;
    logic [XY_W-1:0]   out_y;
    logic [CNTO_W-1:0] count;
    logic              is_empty;
  } ocs_out_t;

  // Per-cell control: take the neighbor's entry, or load the write data
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

/* rtl/core/ocs_cell.sv */
// ----------------------------------------------------------------------------
// ocs_cell
// One storage cell of the entry ring: holds one (x,y) point and either takes
// its upper neighbor's point or loads a new point, and holds its point otherwise.
// ----------------------------------------------------------------------------
module ocs_cell #(
  parameter int W = 8
) (
  input  logic               clk,
  input  ocs_pkg::cell_ctrl_t ctrl,
  input  logic [W-1:0]       nb_x,
  input  logic [W-1:0]       nb_y,
  input  logic [W-1:0]       wr_x,
  input  logic [W-1:0]       wr_y,
  output logic [W-1:0]       x,
  output logic [W-1:0]       y
);
  import ocs_pkg::*;

  logic [W-1:0] x_r;
  logic [W-1:0] y_r;

  // Advance from the neighbor, load a new point, or hold
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      x_r <= nb_x;
      y_r <= nb_y;
    end else if (ctrl.load) begin
      x_r <= wr_x;
      y_r <= wr_y;
    end
  end

  assign x = x_r;
  assign y = y_r;

endmodule

/* rtl/core/ocs_mod.sv */
// ----------------------------------------------------------------------------
// ocs_mod
// Restoring remainder unit: reduces a 16-bit value modulo the entry count,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ocs_mod #(
  parameter int DW = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ocs_pkg::RND_W-1:0] dividend,
  input  logic [DW-1:0]            divisor,
  output logic                     done,
  output logic [DW-1:0]            rem
);
  import ocs_pkg::*;

  localparam int STEP_W = $clog2(RND_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [RND_W-1:0]  dvd_r;
  logic [DW-1:0]     dvs_r;
  logic [DW-1:0]     rem_r;
  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic [DW-1:0]     rem_nxt;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial   = {rem_r, dvd_r[RND_W-1]};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = (trial >= {1'b0, dvs_r}) ? diff[DW-1:0] : trial[DW-1:0];
  end

  // Control: run one step per cycle for every dividend bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(RND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[RND_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* rtl/core/ordered_coordinate_set.sv */
// Flow: insert, remove, find and read turn the ring once and then raise the result in the
//   update step; random pick computes the remainder first; unused codes go straight to update.
// One transaction at a time: the next is accepted only after the update step of the last.
// A new transaction is accepted while the previous result waits in the output register;
//   the update step stalls while that register is still full.
// Reset clears the entry count, the controller and the output valid; points are not cleared.
// ----------------------------------------------------------------------------
// ordered_coordinate_set
// Insertion-ordered set of distinct (x,y) points kept in a ring of cells that
// rotates once per transaction for search, read and pick.
// ----------------------------------------------------------------------------
module ordered_coordinate_set #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ocs_pkg::ocs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ocs_pkg::ocs_out_t out_data
);
  import ocs_pkg::*;

  localparam int CW    = (COORD_BITS < XY_W) ? COORD_BITS : XY_W;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = CNT_W + POS_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  scan_i_r;
  logic [OP_W-1:0]   op_r;
  logic [CW-1:0]     key_x_r, key_y_r;
  logic [CMP_W-1:0]  tgt_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hpos_r;
  logic [CW-1:0]     cap_x_r, cap_y_r;
  logic              out_valid_r;
  ocs_out_t          out_data_r;
  ocs_out_t          res;

  logic in_fire, upd_fire, mod_start, mod_done;
  logic do_load, do_close;
  logic [CNT_W-1:0] mod_rem;
  logic [CW-1:0]    cell_x [CAPACITY];
  logic [CW-1:0]    cell_y [CAPACITY];
  logic             head_match;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign upd_fire  = (state_r == ST_UPD) && (!out_valid_r || out_ready);
  assign mod_start = in_fire && (in_data.op == OP_PICK);

  // Remainder unit for the random pick
  ocs_mod #(.DW(CNT_W)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_data.random_value),
    .divisor  (count_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Ring of cells: cell k takes from cell k+1, the top cell from cell 0
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam int NB = (k == CAPACITY - 1) ? 0 : k + 1;
    cell_ctrl_t ctrl;
    always_comb begin
      ctrl.shift = (state_r == ST_SCAN) || (do_close && (IDX_W'(k) >= hpos_r));
      ctrl.load  = do_load && (CNT_W'(k) == count_r);
    end
    ocs_cell #(.W(CW)) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .nb_x (cell_x[NB]),
      .nb_y (cell_y[NB]),
      .wr_x (key_x_r),
      .wr_y (key_y_r),
      .x    (cell_x[k]),
      .y    (cell_y[k])
    );
  end

  // Compare the entry at the head of the ring with the key
  assign head_match = (cell_x[0] == key_x_r) && (cell_y[0] == key_y_r) &&
                      (CNT_W'(scan_i_r) < count_r);

  // Form the result and the state update for the current transaction
  always_comb begin
    res       = '0;
    count_nxt = count_r;
    do_load   = 1'b0;
    do_close  = 1'b0;
    case (op_r)
      OP_INSERT: begin
        if (hit_r) begin
          res.status   = STAT_PRESENT;
          res.found    = 1'b1;
          res.position = POS_W'(hpos_r);
        end else if (count_r == CNT_W'(CAPACITY)) begin
          res.status = STAT_FULL;
        end else begin
          res.position = POS_W'(count_r);
          count_nxt    = count_r + 1'b1;
          do_load      = upd_fire;
        end
      end
      OP_REMOVE: begin
        if (hit_r) begin
          res.found    = 1'b1;
          res.position = POS_W'(hpos_r);
          count_nxt    = count_r - 1'b1;
          do_close     = upd_fire;
        end else begin
          res.status = STAT_NOTFOUND;
        end
      end
      OP_FIND: begin
        if (hit_r) begin
          res.found    = 1'b1;
          res.position = POS_W'(hpos_r);
        end else begin
          res.status = STAT_NOTFOUND;
        end
      end
      OP_READ: begin
        if (tgt_r < CMP_W'(count_r)) begin
          res.position = POS_W'(tgt_r);
          res.out_x    = XY_W'(cap_x_r);
          res.out_y    = XY_W'(cap_y_r);
        end else begin
          res.status = STAT_RANGE;
        end
      end
      OP_PICK: begin
        if (count_r == '0) begin
          res.status = STAT_RANGE;
        end else begin
          res.position = POS_W'(tgt_r);
          res.out_x    = XY_W'(cap_x_r);
          res.out_y    = XY_W'(cap_y_r);
        end
      end
      default: ;
    endcase
    res.count    = CNTO_W'(count_nxt);
    res.is_empty = (count_nxt == '0);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.op == OP_PICK) begin
            state_nxt = ST_MOD;
          end else if (in_data.op == OP_INSERT || in_data.op == OP_REMOVE ||
                       in_data.op == OP_FIND || in_data.op == OP_READ) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_UPD;
          end
        end
      end
      ST_MOD:  if (mod_done) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_i_r == IDX_W'(CAPACITY - 1)) state_nxt = ST_UPD;
      ST_UPD:  if (upd_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Transaction registers, scan walk and captures
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_data.op;
      key_x_r  <= CW'(in_data.coord_x);
      key_y_r  <= CW'(in_data.coord_y);
      tgt_r    <= CMP_W'(in_data.entry_index);
      scan_i_r <= '0;
      hit_r    <= 1'b0;
      hpos_r   <= '0;
    end
    if (state_r == ST_MOD && mod_done) begin
      tgt_r <= CMP_W'(mod_rem);
    end
    if (state_r == ST_SCAN) begin
      scan_i_r <= scan_i_r + 1'b1;
      if (head_match && !hit_r) begin
        hit_r  <= 1'b1;
        hpos_r <= scan_i_r;
      end
      if (CMP_W'(scan_i_r) == tgt_r) begin
        cap_x_r <= cell_x[0];
        cap_y_r <= cell_y[0];
      end
    end
    if (upd_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_out_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPD))
    else $error("result raised outside the update step");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_i_r == IDX_W'(CAPACITY - 1)) |=> (state_r == ST_UPD))
    else $error("ring turn did not end in the update step");

  a_count_upd: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |-> $past(upd_fire))
    else $error("entry count changed outside an update");

  a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == ST_MOD))
    else $error("remainder finished outside the modulo step");

endmodule
